// File: rtl/nsh_pkg.sv
// Shared types, codes and sizes for the sustain note holder.
package nsh_pkg;

  // Slot table size and the widths that follow from it
  localparam int NUM_SLOTS = 16;
  localparam int IDX_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CNT_W     = $clog2(NUM_SLOTS + 1);

  // Queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // Pedal controller number and down threshold
  localparam logic [6:0] PEDAL_CTRL   = 7'd64;
  localparam logic [6:0] PEDAL_THRESH = 7'd64;

  // Input command codes
  localparam logic [2:0] CMD_NOTE_ON  = 3'd0;
  localparam logic [2:0] CMD_NOTE_OFF = 3'd1;
  localparam logic [2:0] CMD_CTRL     = 3'd2;
  localparam logic [2:0] CMD_OTHER    = 3'd3;
  localparam logic [2:0] CMD_BOUNDARY = 3'd4;

  // Result kind codes
  localparam logic [1:0] KIND_NOTE_OFF = 2'd1;

  // Channel used for released notes
  localparam logic [4:0] RELEASE_CHANNEL = 5'd1;

  typedef struct packed {
    logic [2:0]  command;
    logic [4:0]  channel;
    logic [6:0]  data_first;
    logic [6:0]  data_second;
    logic [15:0] sample_pos;
    logic        gui_hold;
  } item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [4:0]  out_channel;
    logic [6:0]  out_first;
    logic [6:0]  out_second;
    logic [15:0] out_pos;
    logic        last;
    logic [4:0]  held_count;
  } result_t;

  // Classified operation handed from front to back
  typedef enum logic [2:0] {
    OP_PASS,
    OP_PEDAL,
    OP_NOTE_ON,
    OP_NOTE_OFF,
    OP_BOUNDARY
  } op_code_t;

  typedef struct packed {
    op_code_t    op;
    logic [1:0]  kind;
    logic [4:0]  channel;
    logic [6:0]  first;
    logic [6:0]  second;
    logic [15:0] pos;
    logic        flag;   // pedal down for OP_PEDAL, gui hold for OP_BOUNDARY
  } op_t;

endpackage

// File: rtl/nsh_front.sv
// Front end: accepts input transfers and classifies them into queue operations.
module nsh_front (
  input  logic          item_valid,
  input  nsh_pkg::item_t item,
  output logic          item_stall,
  input  logic          q_full,
  output logic          q_push,
  output nsh_pkg::op_t  q_op
);
  import nsh_pkg::*;

  logic known;

  // Hold off the sender while the queue is full
  assign item_stall = q_full;

  // Classify the command; unknown commands are taken and dropped
  always_comb begin
    known      = 1'b1;
    q_op.op    = OP_PASS;
    q_op.kind  = item.command[1:0];
    q_op.channel = item.channel;
    q_op.first = item.data_first;
    q_op.second = item.data_second;
    q_op.pos   = item.sample_pos;
    q_op.flag  = 1'b0;
    case (item.command)
      CMD_NOTE_ON: begin
        q_op.op = (item.data_second != 7'd0) ? OP_NOTE_ON : OP_NOTE_OFF;
      end
      CMD_NOTE_OFF: begin
        q_op.op = OP_NOTE_OFF;
      end
      CMD_CTRL: begin
        if (item.data_first == PEDAL_CTRL) begin
          q_op.op   = OP_PEDAL;
          q_op.flag = (item.data_second >= PEDAL_THRESH);
        end
      end
      CMD_OTHER: begin
        q_op.op = OP_PASS;
      end
      CMD_BOUNDARY: begin
        q_op.op   = OP_BOUNDARY;
        q_op.flag = item.gui_hold;
      end
      default: begin
        known = 1'b0;
      end
    endcase
  end

  assign q_push = item_valid && !item_stall && known;

endmodule

// File: rtl/nsh_queue.sv
// Short operation queue between the front end and the slot engine.
module nsh_queue (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  nsh_pkg::op_t push_op,
  output logic         full,
  input  logic         pop,
  output nsh_pkg::op_t pop_op,
  output logic         empty
);
  import nsh_pkg::*;

  op_t               entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   fill;

  assign full   = (fill == (QPTR_W+1)'(QUEUE_DEPTH));
  assign empty  = (fill == '0);
  assign pop_op = entries[rd_ptr];

  // Store pushed operations
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_op;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

`ifndef ASSERT_OFF
  a_no_push_full: assert property (@(posedge clk) disable iff (rst) full |-> !push)
    else $error("queue pushed while full");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) empty |-> !pop)
    else $error("queue popped while empty");
`endif

endmodule

// File: rtl/nsh_back.sv
// Slot engine: walks the note slot table one slot a cycle and drives results, waiting while a result is stalled.
module nsh_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_empty,
  input  nsh_pkg::op_t    q_op,
  output logic            q_pop,
  output logic            result_valid,
  output nsh_pkg::result_t result,
  input  logic            result_stall
);
  import nsh_pkg::*;

  typedef enum logic [0:0] {
    S_IDLE,
    S_RUN
  } state_t;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SLOTS - 1);

  state_t               state;
  op_t                  cur;
  logic [IDX_W-1:0]     idx;
  logic [6:0]           slot_note [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] slot_used;
  logic [NUM_SLOTS-1:0] slot_held;
  logic                 pedal_down;
  logic                 hold_active;
  logic [CNT_W-1:0]     count;

  logic                 can_emit;
  logic                 at_end;
  logic                 slot_free;
  logic                 slot_match;
  logic                 more_held;
  logic [NUM_SLOTS-1:0] above_mask;
  logic [CNT_W-1:0]     count_inc;
  logic [CNT_W-1:0]     count_dec;
  logic                 boundary_hold;

  // Per-slot decode at the scan index
  assign can_emit   = !result_valid || !result_stall;
  assign at_end     = (idx == LAST_IDX);
  assign slot_free  = !slot_used[idx];
  assign slot_match = slot_used[idx] && (slot_note[idx] == cur.first);
  assign count_inc  = count + 1'b1;
  assign count_dec  = count - 1'b1;
  assign q_pop      = (state == S_IDLE) && !q_empty;
  assign boundary_hold = pedal_down || q_op.flag;

  // Mark slots above the scan index, to spot the final release
  always_comb begin
    for (int j = 0; j < NUM_SLOTS; j++) begin
      above_mask[j] = (IDX_W'(j) > idx);
    end
  end
  assign more_held = |(slot_held & above_mask);

  // Sequence operations and hold the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      idx          <= '0;
      slot_used    <= '0;
      slot_held    <= '0;
      pedal_down   <= 1'b0;
      hold_active  <= 1'b0;
      count        <= '0;
      result_valid <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (!q_empty) begin
            cur <= q_op;
            idx <= '0;
            if (q_op.op == OP_BOUNDARY) begin
              hold_active <= boundary_hold;
              if (!boundary_hold) begin
                state <= S_RUN;
              end
            end else begin
              state <= S_RUN;
            end
          end
        end
        S_RUN: begin
          case (cur.op)
            OP_PASS, OP_PEDAL: begin
              if (can_emit) begin
                if (cur.op == OP_PEDAL) begin
                  pedal_down <= cur.flag;
                end
                result_valid <= 1'b1;
                result <= '{cur.kind, cur.channel, cur.first, cur.second, cur.pos,
                            1'b1, 5'(count)};
                state  <= S_IDLE;
              end
            end
            OP_NOTE_ON: begin
              if (slot_free) begin
                if (can_emit) begin
                  slot_used[idx] <= 1'b1;
                  slot_note[idx] <= cur.first;
                  count          <= count_inc;
                  result_valid   <= 1'b1;
                  result <= '{cur.kind, cur.channel, cur.first, cur.second, cur.pos,
                              1'b1, 5'(count_inc)};
                  state  <= S_IDLE;
                end
              end else if (at_end) begin
                // Table full: pass the note-on unchanged
                if (can_emit) begin
                  result_valid <= 1'b1;
                  result <= '{cur.kind, cur.channel, cur.first, cur.second, cur.pos,
                              1'b1, 5'(count)};
                  state  <= S_IDLE;
                end
              end else begin
                idx <= idx + 1'b1;
              end
            end
            OP_NOTE_OFF: begin
              if (slot_match) begin
                if (hold_active) begin
                  // Swallow the note-off and keep the note sounding
                  slot_held[idx] <= 1'b1;
                  state          <= S_IDLE;
                end else if (can_emit) begin
                  slot_used[idx] <= 1'b0;
                  slot_held[idx] <= 1'b0;
                  count          <= count_dec;
                  result_valid   <= 1'b1;
                  result <= '{cur.kind, cur.channel, cur.first, cur.second, cur.pos,
                              1'b1, 5'(count_dec)};
                  state  <= S_IDLE;
                end
              end else if (at_end) begin
                // No matching slot: pass the note-off unchanged
                if (can_emit) begin
                  result_valid <= 1'b1;
                  result <= '{cur.kind, cur.channel, cur.first, cur.second, cur.pos,
                              1'b1, 5'(count)};
                  state  <= S_IDLE;
                end
              end else begin
                idx <= idx + 1'b1;
              end
            end
            OP_BOUNDARY: begin
              if (slot_held[idx]) begin
                // Release a held note
                if (can_emit) begin
                  slot_used[idx] <= 1'b0;
                  slot_held[idx] <= 1'b0;
                  count          <= count_dec;
                  result_valid   <= 1'b1;
                  result <= '{KIND_NOTE_OFF, RELEASE_CHANNEL, slot_note[idx], 7'd0,
                              16'd0, !more_held, 5'(count_dec)};
                  if (!more_held || at_end) begin
                    state <= S_IDLE;
                  end else begin
                    idx <= idx + 1'b1;
                  end
                end
              end else if (at_end) begin
                state <= S_IDLE;
              end else begin
                idx <= idx + 1'b1;
              end
            end
            default: begin
              state <= S_IDLE;
            end
          endcase
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_count_matches: assert property (@(posedge clk) disable iff (rst)
      count == CNT_W'($countones(slot_used)))
    else $error("occupancy count out of step with used slots");
  a_held_is_used: assert property (@(posedge clk) disable iff (rst)
      (slot_held & ~slot_used) == '0)
    else $error("held slot not occupied");
  a_hold_no_release: assert property (@(posedge clk) disable iff (rst)
      (state == S_RUN && cur.op == OP_BOUNDARY) |-> !hold_active)
    else $error("release scan running while hold is active");
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
      (result_valid && result_stall) |=> (result_valid && $stable(result)))
    else $error("stalled result changed");
`endif

endmodule

// File: rtl/midi_sustain_note_holder_core.sv
// Top level of the sustain note holder: front end, operation queue and slot engine.
//
// Input channel (item_valid / item / item_stall): one MIDI event or block-boundary
// marker per transfer. Unknown commands are taken and dropped.
// Output channel (result_valid / result / result_stall): zero or more results per
// input; result.last marks the final one of each input.
// Order of work: an input is classified into the queue, and the engine takes it from
// the queue head only when idle; a pass-through event or controller then gives its
// result from the output register. Note-on and note-off walk the slot table one slot
// per cycle, waiting at the slot that gives a result while the output is stalled; a
// note-off swallowed under hold gives no result. A boundary with hold on ends as it
// is taken; with hold off it walks the slots up to the last held one (all NUM_SLOTS
// when none is held) and emits one released note-off per held slot.
// A queue of QUEUE_DEPTH operations lets new items be taken while the engine works
// or its result waits; item_stall rises only when that queue is full.
// A stalled result holds in the output register and the engine waits on it.
// Reset (rst, synchronous) empties the queue, frees all slots, clears the pedal
// and hold flags and drops any pending result. No clearing pass is needed.
module midi_sustain_note_holder_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  input  nsh_pkg::item_t   item,
  output logic             item_stall,
  output logic             result_valid,
  output nsh_pkg::result_t result,
  input  logic             result_stall
);
  import nsh_pkg::*;

  logic q_push;
  logic q_full;
  logic q_pop;
  logic q_empty;
  op_t  push_op;
  op_t  head_op;

  // Classify incoming transfers
  nsh_front u_front (
    .item_valid (item_valid),
    .item       (item),
    .item_stall (item_stall),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_op       (push_op)
  );

  // Buffer classified operations
  nsh_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .push_op (push_op),
    .full    (q_full),
    .pop     (q_pop),
    .pop_op  (head_op),
    .empty   (q_empty)
  );

  // Carry out operations over the slot table
  nsh_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_empty      (q_empty),
    .q_op         (head_op),
    .q_pop        (q_pop),
    .result_valid (result_valid),
    .result       (result),
    .result_stall (result_stall)
  );

endmodule
